[rtl/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and constants for the epoch / calendar converter.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int TS_W    = 32;
  localparam int EPOCH_W = 33;
  localparam int MASK_W  = 8;

  localparam logic [11:0] BASE_YEAR   = 12'd1970;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // Day of year at which month m starts, counted from 0. Month 0 and 1 both
  // start at 0; months 13 and 14 are taken as 30 days each.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      4'd13:   base = 9'd365;
      4'd14:   base = 9'd395;
      4'd15:   base = 9'd425;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (m >= 4'd3)) ? 1 : 0);
  endfunction

endpackage

[rtl/ecc_split.sv]
// ----------------------------------------------------------------------------
// ecc_split
// Six-stage pipeline that splits epoch seconds into calendar fields.
// Calendar requests pass through unchanged.
// ----------------------------------------------------------------------------
module ecc_split
  import ecc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  logic            req_func,
  input  logic [TS_W-1:0] req_ts,
  input  cal_t            req_cal,
  output logic            res_valid,
  input  logic            res_ready,
  output logic            res_func,
  output logic [TS_W-1:0] res_ts,
  output cal_t            res_cal
);

  localparam int NS = 6;

  // reciprocal constants, exact over the operand widths used
  localparam logic [25:0] DAY_MAGIC   = 26'd50903317; // ceil(2^35 / 675)
  localparam logic [13:0] HOUR_MAGIC  = 14'd9321;     // ceil(2^21 / 225)
  localparam logic [10:0] MIN_MAGIC   = 11'd1093;     // ceil(2^14 / 15)
  localparam logic [11:0] YEAR_RECIP  = 12'd2871;     // ~2^20 / 365.24, fixed up later
  localparam logic [7:0]  CENTURY_OFF = 8'd130;       // 2100 is not a leap year

  // days from 1970-01-01 to the first day of year 1970+n
  function automatic logic [15:0] year_start(input logic [7:0] n);
    logic [16:0] acc;
    acc = 17'(n) * 17'd365 + 17'((9'(n) + 9'd1) >> 2);
    if (n > CENTURY_OFF) begin
      acc = acc - 17'd1;
    end
    return acc[15:0];
  endfunction

  logic [NS-1:0]   vld;
  logic [NS-1:0]   rdy;
  logic            st_func [NS];
  logic [TS_W-1:0] st_ts   [NS];
  cal_t            st_cal  [NS-1];

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || res_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign req_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= req_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_func[0] <= req_func;
      st_ts[0]   <= req_ts;
      st_cal[0]  <= req_cal;
    end
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        st_func[i] <= st_func[i-1];
        st_ts[i]   <= st_ts[i-1];
      end
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (rdy[i]) st_cal[i] <= st_cal[i-1];
    end
  end

  // stage 0: whole days
  logic [50:0] day_prod;
  logic [15:0] days0;

  assign day_prod = 51'(req_ts[TS_W-1:7]) * 51'(DAY_MAGIC);

  always_ff @(posedge clk) begin
    if (rdy[0]) days0 <= day_prod[50:35];
  end

  // stage 1: second of day, year estimate
  logic [24:0] sod_hi;
  logic [27:0] yr_prod;
  logic [15:0] days1;
  logic [16:0] sod1;
  logic [7:0]  nest1;

  assign sod_hi  = st_ts[0][TS_W-1:7] - 25'(days0) * 25'd675;
  assign yr_prod = 28'(days0) * 28'(YEAR_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      days1 <= days0;
      sod1  <= {sod_hi[9:0], st_ts[0][6:0]};
      nest1 <= yr_prod[27:20];
    end
  end

  // stage 2: hour, candidate year starts
  logic [26:0] hr_prod;
  logic [15:0] days2;
  logic [16:0] sod2;
  logic [7:0]  nest2;
  logic [4:0]  hr2;
  logic [15:0] ys_lo2, ys_mid2, ys_hi2;

  assign hr_prod = 27'(sod1[16:4]) * 27'(HOUR_MAGIC);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      days2   <= days1;
      sod2    <= sod1;
      nest2   <= nest1;
      hr2     <= hr_prod[25:21];
      ys_lo2  <= year_start(nest1 - 8'd1);
      ys_mid2 <= year_start(nest1);
      ys_hi2  <= year_start(nest1 + 8'd1);
    end
  end

  // stage 3: seconds within the hour, year fix-up by one either way
  logic [16:0] rem_full;
  logic [7:0]  yoff_c;
  logic [15:0] doy_c;
  logic [11:0] rem3;
  logic [4:0]  hr3;
  logic [7:0]  yoff3;
  logic [8:0]  doy3;
  logic        leap3;

  assign rem_full = sod2 - 17'(hr2) * 17'd3600;

  always_comb begin
    if (days2 < ys_mid2) begin
      yoff_c = nest2 - 8'd1;
      doy_c  = days2 - ys_lo2;
    end else if (days2 >= ys_hi2) begin
      yoff_c = nest2 + 8'd1;
      doy_c  = days2 - ys_hi2;
    end else begin
      yoff_c = nest2;
      doy_c  = days2 - ys_mid2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rem3  <= rem_full[11:0];
      hr3   <= hr2;
      yoff3 <= yoff_c;
      doy3  <= doy_c[8:0];
      leap3 <= (yoff_c[1:0] == 2'd2) && (yoff_c != CENTURY_OFF);
    end
  end

  // stage 4: minute, month
  logic [20:0] mi_prod;
  logic [3:0]  mon_c;
  logic [11:0] rem4;
  logic [4:0]  hr4;
  logic [5:0]  mi4;
  logic [7:0]  yoff4;
  logic [8:0]  doy4;
  logic        leap4;
  logic [3:0]  mon4;

  assign mi_prod = 21'(rem3[11:2]) * 21'(MIN_MAGIC);

  always_comb begin
    mon_c = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (doy3 >= month_start(4'(m), leap3)) mon_c = mon_c + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      rem4  <= rem3;
      hr4   <= hr3;
      mi4   <= mi_prod[19:14];
      yoff4 <= yoff3;
      doy4  <= doy3;
      leap4 <= leap3;
      mon4  <= mon_c;
    end
  end

  // stage 5: day, second, select decoded or passed-through fields
  cal_t        dec;
  cal_t        cal5;
  logic [11:0] sec_full;
  logic [8:0]  day_full;

  assign sec_full = rem4 - 12'(mi4) * 12'd60;
  assign day_full = doy4 - month_start(mon4, leap4) + 9'd1;

  always_comb begin
    dec.year   = BASE_YEAR + 12'(yoff4);
    dec.month  = mon4;
    dec.day    = day_full[4:0];
    dec.hour   = hr4;
    dec.minute = mi4;
    dec.second = sec_full[5:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) cal5 <= st_func[NS-2] ? st_cal[NS-2] : dec;
  end

  assign res_valid = vld[NS-1];
  assign res_func  = st_func[NS-1];
  assign res_ts    = st_ts[NS-1];
  assign res_cal   = cal5;

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_func) |->
      (res_cal.month >= 4'd1 && res_cal.month <= 4'd12 &&
       res_cal.day >= 5'd1 && res_cal.day <= 5'd31))
    else $error("decoded month or day out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_func) |->
      (res_cal.year >= BASE_YEAR && res_cal.year <= 12'd2106 &&
       res_cal.hour <= 5'd23 && res_cal.minute <= 6'd59 && res_cal.second <= 6'd59))
    else $error("decoded year or time of day out of range");

endmodule

[rtl/ecc_encode.sv]
// ----------------------------------------------------------------------------
// ecc_encode
// Five-stage pipeline: weekday and epoch seconds from calendar fields,
// then extract masking into the result register.
// ----------------------------------------------------------------------------
module ecc_encode
  import ecc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               req_func,
  input  logic [TS_W-1:0]    req_ts,
  input  cal_t               req_cal,
  input  logic [MASK_W-1:0]  extract_mask,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [11:0]        res_year,
  output logic [3:0]         res_month,
  output logic [4:0]         res_day,
  output logic [4:0]         res_hour,
  output logic [5:0]         res_minute,
  output logic [5:0]         res_second,
  output logic [2:0]         res_weekday,
  output logic [EPOCH_W-1:0] res_epoch
);

  localparam int NS = 5;

  localparam int MB_YEAR    = 0;
  localparam int MB_MONTH   = 1;
  localparam int MB_DAY     = 2;
  localparam int MB_HOUR    = 3;
  localparam int MB_MINUTE  = 4;
  localparam int MB_SECOND  = 5;
  localparam int MB_WEEKDAY = 6;
  localparam int MB_EPOCH   = 7;

  localparam logic [12:0] DIV100_MAGIC = 13'd5243;  // ceil(2^19 / 100)
  localparam logic [13:0] MOD7_MAGIC   = 14'd9363;  // ceil(2^16 / 7)
  localparam logic [19:0] LEAPS_1969   = 20'd477;   // leap years up to 1969

  // Sakamoto month offsets; month 0 as January, 13..15 as December
  function automatic logic [2:0] wd_offset(input logic [3:0] m);
    case (m)
      4'd2:    return 3'd3;
      4'd3:    return 3'd2;
      4'd4:    return 3'd5;
      4'd5:    return 3'd0;
      4'd6:    return 3'd3;
      4'd7:    return 3'd5;
      4'd8:    return 3'd1;
      4'd9:    return 3'd4;
      4'd10:   return 3'd6;
      4'd11:   return 3'd2;
      4'd12:   return 3'd4;
      4'd13:   return 3'd4;
      4'd14:   return 3'd4;
      4'd15:   return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  logic [NS-1:0]   vld;
  logic [NS-1:0]   rdy;
  logic            st_func [NS-1];
  logic [TS_W-1:0] st_ts   [NS-1];
  cal_t            st_cal  [NS-1];

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || res_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign req_ready = rdy[0];
  assign res_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= req_valid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      st_func[0] <= req_func;
      st_ts[0]   <= req_ts;
      st_cal[0]  <= req_cal;
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (rdy[i]) begin
        st_func[i] <= st_func[i-1];
        st_ts[i]   <= st_ts[i-1];
        st_cal[i]  <= st_cal[i-1];
      end
    end
  end

  // stage 0: year / 100
  logic [24:0] qy_prod;
  logic [5:0]  qy0;

  assign qy_prod = 25'(req_cal.year) * 25'(DIV100_MAGIC);

  always_ff @(posedge clk) begin
    if (rdy[0]) qy0 <= qy_prod[24:19];
  end

  // stage 1: century terms for y-1 and the weekday year, leap flag, time of day
  logic        zr;
  logic [7:0]  qym1_c;
  logic [7:0]  qym1_1;
  logic [7:0]  qyy1;
  logic        leap1;
  logic [16:0] tod1;

  assign zr     = (12'(qy0) * 12'd100) == st_cal[0].year;
  assign qym1_c = 8'(qy0) - 8'(zr);  // wraps for year zero; weekday fix of +4 covers it

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      qym1_1 <= qym1_c;
      qyy1   <= ((st_cal[0].month < 4'd3) ? qym1_c : 8'(qy0)) + 8'd4;
      leap1  <= (st_cal[0].year[1:0] == 2'd0) && (!zr || (qy0[1:0] == 2'd0));
      tod1   <= 17'(st_cal[0].hour) * 17'd3600 + 17'(st_cal[0].minute) * 17'd60 +
                17'(st_cal[0].second);
    end
  end

  // stage 2: day count and weekday sum
  logic [11:0] y2;
  logic [11:0] ym1;
  logic [12:0] yy;
  logic [10:0] lc;
  logic [19:0] ydays;
  logic [19:0] days_c;
  logic [12:0] wsum_c;
  logic [19:0] days2;
  logic [12:0] wsum2;
  logic [16:0] tod2;

  assign y2  = st_cal[1].year;
  assign ym1 = y2 - 12'd1;
  assign yy  = 13'(y2) + 13'd400 - 13'((st_cal[1].month < 4'd3) ? 1 : 0);
  assign lc  = 11'(ym1[11:2]) - 11'(qym1_1) + 11'(qym1_1[7:2]);

  always_comb begin
    if (y2 > BASE_YEAR) begin
      ydays = 20'(y2 - BASE_YEAR) * 20'd365 + 20'(lc) - LEAPS_1969;
    end else begin
      ydays = '0;
    end
    days_c = ydays + 20'(month_start(st_cal[1].month, leap1)) + 20'(st_cal[1].day);
    wsum_c = yy + 13'(yy[12:2]) - 13'(qyy1) + 13'(qyy1[7:2]) +
             13'(wd_offset(st_cal[1].month)) + 13'(st_cal[1].day);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      days2 <= days_c;
      wsum2 <= wsum_c;
      tod2  <= tod1;
    end
  end

  // stage 3: epoch seconds (day count includes the current day, hence one
  // day taken back), weekday quotient
  logic [36:0]        e_prod;
  logic [26:0]        wq_prod;
  logic [EPOCH_W-1:0] epoch3;
  logic [9:0]         wq3;
  logic [12:0]        wsum3;

  assign e_prod  = 37'(days2) * 37'(SEC_PER_DAY);
  assign wq_prod = 27'(wsum2) * 27'(MOD7_MAGIC);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      epoch3 <= e_prod[EPOCH_W-1:0] + EPOCH_W'(tod2) - EPOCH_W'(SEC_PER_DAY);
      wq3    <= wq_prod[25:16];
      wsum3  <= wsum2;
    end
  end

  // stage 4: result register
  logic [12:0]        wd_full;
  logic [EPOCH_W-1:0] epoch_sel;
  cal_t               c3;

  assign c3        = st_cal[3];
  assign wd_full   = wsum3 - 13'(wq3) * 13'd7;
  assign epoch_sel = st_func[3] ? epoch3 : EPOCH_W'(st_ts[3]);

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      res_year    <= extract_mask[MB_YEAR]    ? c3.year    : '0;
      res_month   <= extract_mask[MB_MONTH]   ? c3.month   : '0;
      res_day     <= extract_mask[MB_DAY]     ? c3.day     : '0;
      res_hour    <= extract_mask[MB_HOUR]    ? c3.hour    : '0;
      res_minute  <= extract_mask[MB_MINUTE]  ? c3.minute  : '0;
      res_second  <= extract_mask[MB_SECOND]  ? c3.second  : '0;
      res_weekday <= extract_mask[MB_WEEKDAY] ? wd_full[2:0] : '0;
      res_epoch   <= extract_mask[MB_EPOCH]   ? epoch_sel  : '0;
    end
  end

  a_weekday: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_weekday <= 3'd6)
    else $error("weekday remainder out of range");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> &vld)
    else $error("pipeline back-pressured with an empty stage");

endmodule

[rtl/epoch_calendar_converter.sv]
// ----------------------------------------------------------------------------
// epoch_calendar_converter
// Converts a timestamp between epoch seconds and Gregorian calendar fields,
// adds weekday and epoch, and masks the result fields.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | req_valid/req_ready  | func, epoch_seconds, in_year .. in_second
//  result   | res_valid/res_ready  | out_year .. out_second, out_weekday, out_epoch
//  config   | cfg_we               | cfg_wdata (extract_mask)
//
//  One request per cycle while req_ready is high; 11 register stages (6 split +
//  5 encode) lie between a request and its result.
//  Stall-free stages collapse bubbles, so requests are taken while a result waits.
//  req_ready drops only when every stage holds a request and res_ready is low.
//  Reset clears the stage valid bits and sets extract_mask to all ones.
// ----------------------------------------------------------------------------
module epoch_calendar_converter
  import ecc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               func,
  input  logic [TS_W-1:0]    epoch_seconds,
  input  logic [11:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic [2:0]         out_weekday,
  output logic [EPOCH_W-1:0] out_epoch,
  input  logic               cfg_we,
  input  logic [MASK_W-1:0]  cfg_wdata
);

  logic [MASK_W-1:0] extract_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      extract_mask <= '1;
    end else if (cfg_we) begin
      extract_mask <= cfg_wdata;
    end
  end

  cal_t            in_cal;
  logic            mid_valid, mid_ready, mid_func;
  logic [TS_W-1:0] mid_ts;
  cal_t            mid_cal;

  always_comb begin
    in_cal.year   = in_year;
    in_cal.month  = in_month;
    in_cal.day    = in_day;
    in_cal.hour   = in_hour;
    in_cal.minute = in_minute;
    in_cal.second = in_second;
  end

  ecc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_func  (func),
    .req_ts    (epoch_seconds),
    .req_cal   (in_cal),
    .res_valid (mid_valid),
    .res_ready (mid_ready),
    .res_func  (mid_func),
    .res_ts    (mid_ts),
    .res_cal   (mid_cal)
  );

  ecc_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (mid_valid),
    .req_ready    (mid_ready),
    .req_func     (mid_func),
    .req_ts       (mid_ts),
    .req_cal      (mid_cal),
    .extract_mask (extract_mask),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_year     (out_year),
    .res_month    (out_month),
    .res_day      (out_day),
    .res_hour     (out_hour),
    .res_minute   (out_minute),
    .res_second   (out_second),
    .res_weekday  (out_weekday),
    .res_epoch    (out_epoch)
  );

endmodule
